// ----- rtl/bezier_segment_split_defines.svh -----
// Assertion macros shared by the bezier segment split RTL.
`ifndef BEZIER_SEGMENT_SPLIT_DEFINES_SVH
`define BEZIER_SEGMENT_SPLIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define BSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define BSS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bss_pkg.sv -----
// Shared types and constants for the bezier segment split pipeline.
package bss_pkg;

  localparam logic [1:0] KIND_LINE  = 2'd0;
  localparam logic [1:0] KIND_QUAD  = 2'd1;
  localparam logic [1:0] KIND_CUBIC = 2'd2;

  // Split parameter 1.0 in Q1.16.
  localparam logic [16:0] T_ONE = 17'd65536;

  // Offset that makes p + 2q + 1 non-negative: 1 + 3 * 2^31.
  localparam logic [33:0] DIV3_BIAS = 34'd6442450945;
  // ceil(2^35 / 3); exact floor division by three for operands below 2^35.
  localparam logic [33:0] DIV3_RECIP = 34'd11453246123;
  localparam int unsigned DIV3_SHIFT = 35;

  // Interpolation lanes per pipeline level: three per axis.
  localparam int unsigned LANES = 6;

  typedef logic signed [31:0] coord_t;
  typedef coord_t [1:0] point_t;
  typedef coord_t [LANES-1:0] lanes_t;

  // One segment as it travels down the pipeline; index 0 is x, 1 is y.
  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] t;
    point_t      p0;
    point_t      p3;
    point_t      q1;
    point_t      q2;
    point_t      a01;
    point_t      a12;
    point_t      a23;
    point_t      b012;
    point_t      b123;
    point_t      c;
  } item_t;

endpackage

// ----- rtl/bss_raise.sv -----
// Three-stage degree raise: turns a quadratic control into two cubic controls.
module bss_raise (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  bss_pkg::item_t item_i,
  output logic           valid_o,
  input  logic           ready_i,
  output bss_pkg::item_t item_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  bss_pkg::item_t it1_q, it2_q, it3_q, it3_d;
  bss_pkg::coord_t raised_a [2];
  bss_pkg::coord_t raised_b [2];

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;
  assign item_o  = it3_q;

  for (genvar c = 0; c < 2; c++) begin : g_axis
    logic signed [34:0] sum_a, sum_b;
    logic [33:0] y_a_q, y_b_q;
    logic [50:0] ph_a_q, pl_a_q, ph_b_q, pl_b_q;
    logic [67:0] prod_a, prod_b;
    logic [31:0] quo_a, quo_b;

    // Stage 1: biased sums p0 + 2q + 1 and 2q + p3 + 1, always non-negative.
    assign sum_a = $signed({{3{item_i.p0[c][31]}}, item_i.p0[c]})
                 + $signed({{2{item_i.q1[c][31]}}, item_i.q1[c], 1'b0})
                 + $signed({1'b0, bss_pkg::DIV3_BIAS});
    assign sum_b = $signed({{3{item_i.p3[c][31]}}, item_i.p3[c]})
                 + $signed({{2{item_i.q1[c][31]}}, item_i.q1[c], 1'b0})
                 + $signed({1'b0, bss_pkg::DIV3_BIAS});

    always_ff @(posedge clk_i) begin
      if (rdy1 && valid_i) begin
        y_a_q <= sum_a[33:0];
        y_b_q <= sum_b[33:0];
      end
    end

    // Stage 2: reciprocal multiply, split into two partial products.
    always_ff @(posedge clk_i) begin
      if (rdy2 && v1_q) begin
        ph_a_q <= 51'(y_a_q[33:17]) * 51'(bss_pkg::DIV3_RECIP);
        pl_a_q <= 51'(y_a_q[16:0]) * 51'(bss_pkg::DIV3_RECIP);
        ph_b_q <= 51'(y_b_q[33:17]) * 51'(bss_pkg::DIV3_RECIP);
        pl_b_q <= 51'(y_b_q[16:0]) * 51'(bss_pkg::DIV3_RECIP);
      end
    end

    // Stage 3: sum partials, shift out the reciprocal scale, remove the bias.
    assign prod_a = {ph_a_q, 17'b0} + 68'(pl_a_q);
    assign prod_b = {ph_b_q, 17'b0} + 68'(pl_b_q);
    assign quo_a  = prod_a[bss_pkg::DIV3_SHIFT +: 32];
    assign quo_b  = prod_b[bss_pkg::DIV3_SHIFT +: 32];
    assign raised_a[c] = $signed({~quo_a[31], quo_a[30:0]});
    assign raised_b[c] = $signed({~quo_b[31], quo_b[30:0]});
  end

  always_comb begin
    it3_d = it2_q;
    case (it2_q.kind)
      bss_pkg::KIND_LINE: begin
        // A line reuses the first interpolation lane as p0 -> p3.
        it3_d.q1 = it2_q.p3;
      end
      bss_pkg::KIND_QUAD: begin
        it3_d.q1[0] = raised_a[0];
        it3_d.q1[1] = raised_a[1];
        it3_d.q2[0] = raised_b[0];
        it3_d.q2[1] = raised_b[1];
      end
      default: begin
        it3_d = it2_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) it1_q <= item_i;
    if (rdy2 && v1_q)    it2_q <= it1_q;
    if (rdy3 && v2_q)    it3_q <= it3_d;
  end

endmodule

// ----- rtl/bss_lerp.sv -----
// Three-stage rounded linear interpolation over a row of independent lanes.
module bss_lerp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bss_pkg::item_t  item_i,
  input  bss_pkg::lanes_t a_i,
  input  bss_pkg::lanes_t b_i,
  output logic            valid_o,
  input  logic            ready_i,
  output bss_pkg::item_t  item_o,
  output bss_pkg::lanes_t r_o
);

  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  bss_pkg::item_t it1_q, it2_q, it3_q;

  assign rdy3    = !v3_q || ready_i;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v3_q;
  assign item_o  = it3_q;

  for (genvar l = 0; l < bss_pkg::LANES; l++) begin : g_lane
    logic [31:0] a1_q, a2_q, r_q;
    logic signed [32:0] d_d, d_q;
    logic signed [50:0] p_q, s_d;

    // Stage 1: difference b - a.
    assign d_d = $signed({b_i[l][31], b_i[l]}) - $signed({a_i[l][31], a_i[l]});

    // Stage 3: a + round((b - a) * t / 2^16), half rounding upward,
    // folded into one add since a * 2^16 has clear low bits.
    assign s_d = p_q + 51'($signed({a2_q, 16'h8000}));

    always_ff @(posedge clk_i) begin
      if (rdy1 && valid_i) begin
        a1_q <= a_i[l];
        d_q  <= d_d;
      end
      if (rdy2 && v1_q) begin
        a2_q <= a1_q;
        p_q  <= 51'(d_q) * 51'($signed({1'b0, it1_q.t}));
      end
      if (rdy3 && v2_q) begin
        r_q <= s_d[47:16];
      end
    end

    assign r_o[l] = $signed(r_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) it1_q <= item_i;
    if (rdy2 && v1_q)    it2_q <= it1_q;
    if (rdy3 && v2_q)    it3_q <= it2_q;
  end

endmodule

// ----- rtl/bss_out.sv -----
// Output register that sends each finished segment as two halves.
module bss_out (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bss_pkg::item_t  item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [1:0]      out_kind_o,
  output logic            is_second_half_o,
  output bss_pkg::coord_t out_start_x_o,
  output bss_pkg::coord_t out_start_y_o,
  output bss_pkg::coord_t out_end_x_o,
  output bss_pkg::coord_t out_end_y_o,
  output bss_pkg::coord_t out_ctrl1_x_o,
  output bss_pkg::coord_t out_ctrl1_y_o,
  output bss_pkg::coord_t out_ctrl2_x_o,
  output bss_pkg::coord_t out_ctrl2_y_o
);

  logic v_q, beat_q;
  logic is_line;
  bss_pkg::item_t item_q;
  bss_pkg::point_t start_pt, end_pt, ctrl1_pt, ctrl2_pt, mid_pt;

  // A new segment loads once the second half of the held one leaves.
  assign ready_o = !v_q || (beat_q && !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q    <= 1'b0;
      beat_q <= 1'b0;
    end else if (ready_o) begin
      v_q    <= valid_i;
      beat_q <= 1'b0;
    end else if (!out_stall_i) begin
      beat_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) item_q <= item_i;
  end

  always_comb begin
    is_line = (item_q.kind == bss_pkg::KIND_LINE);
    mid_pt  = is_line ? item_q.a01 : item_q.c;
    if (!beat_q) begin
      start_pt = item_q.p0;
      end_pt   = mid_pt;
      ctrl1_pt = is_line ? '0 : item_q.a01;
      ctrl2_pt = is_line ? '0 : item_q.b012;
    end else begin
      start_pt = mid_pt;
      end_pt   = item_q.p3;
      ctrl1_pt = is_line ? '0 : item_q.b123;
      ctrl2_pt = is_line ? '0 : item_q.a23;
    end
  end

  assign out_valid_o      = v_q;
  assign out_kind_o       = is_line ? bss_pkg::KIND_LINE : bss_pkg::KIND_CUBIC;
  assign is_second_half_o = beat_q;
  assign out_start_x_o    = start_pt[0];
  assign out_start_y_o    = start_pt[1];
  assign out_end_x_o      = end_pt[0];
  assign out_end_y_o      = end_pt[1];
  assign out_ctrl1_x_o    = ctrl1_pt[0];
  assign out_ctrl1_y_o    = ctrl1_pt[1];
  assign out_ctrl2_x_o    = ctrl2_pt[0];
  assign out_ctrl2_y_o    = ctrl2_pt[1];

endmodule

// ----- rtl/bezier_segment_split.sv -----
// Top level of the bezier segment split: splits one path segment at t into two halves.
//
//   Channel | Handshake                   | Moves per transfer
//   --------+-----------------------------+-------------------------------------------
//   in      | in_valid_i / in_stall_o     | segment kind, split t, four points
//   out     | out_valid_o / out_stall_i   | one half: kind, last flag, four points
//
// Every segment yields two transfers on the out channel, first half then second half.
// The first half leaves after its segment passes one input register, three degree-raise
// stages, three interpolation levels of three stages each, and the output register. A
// segment may enter in every cycle while the pipeline has room; sustained throughput is
// set by the out channel, which carries one half a cycle while out_stall_i is low.
// Reset (rst_ni low, asynchronous) clears all valid bits; data registers are not reset.
// A stall on the out channel backs up stage by stage; empty stages keep filling, so
// nothing is dropped or repeated and in_stall_o rises only when the input register is full.
`include "bezier_segment_split_defines.svh"

module bezier_segment_split (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Segment input.
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             seg_kind_i,
  input  logic [16:0]            split_t_i,
  input  logic signed [31:0]     start_x_i,
  input  logic signed [31:0]     start_y_i,
  input  logic signed [31:0]     end_x_i,
  input  logic signed [31:0]     end_y_i,
  input  logic signed [31:0]     ctrl1_x_i,
  input  logic signed [31:0]     ctrl1_y_i,
  input  logic signed [31:0]     ctrl2_x_i,
  input  logic signed [31:0]     ctrl2_y_i,
  // Half-segment output.
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             out_kind_o,
  output logic                   is_second_half_o,
  output logic signed [31:0]     out_start_x_o,
  output logic signed [31:0]     out_start_y_o,
  output logic signed [31:0]     out_end_x_o,
  output logic signed [31:0]     out_end_y_o,
  output logic signed [31:0]     out_ctrl1_x_o,
  output logic signed [31:0]     out_ctrl1_y_o,
  output logic signed [31:0]     out_ctrl2_x_o,
  output logic signed [31:0]     out_ctrl2_y_o
);

  // Input register.
  logic           in_v_q;
  logic           in_rdy;
  bss_pkg::item_t in_item_q, in_item_d;

  // Degree raise.
  logic           raise_rdy, raise_v;
  bss_pkg::item_t raise_item;

  // Interpolation levels: first (a01, a12, a23), second (b012, b123), third (c).
  logic            l1_rdy, l1_v, l2_rdy, l2_v, l3_rdy, l3_v, out_rdy;
  bss_pkg::lanes_t l1_a, l1_b, l1_r, l2_a, l2_b, l2_r, l3_a, l3_b, l3_r;
  bss_pkg::item_t  l1_side, l1_item, l2_side, l2_item, l3_side, l3_item;

  logic first_xfer;

  // The input register loads whenever it is empty or its content moves on.
  assign in_rdy     = !in_v_q || raise_rdy;
  assign in_stall_o = !in_rdy;

  always_comb begin
    in_item_d       = '0;
    in_item_d.kind  = seg_kind_i;
    // t above one behaves as exactly one.
    in_item_d.t     = (split_t_i > bss_pkg::T_ONE) ? bss_pkg::T_ONE : split_t_i;
    in_item_d.p0[0] = start_x_i;
    in_item_d.p0[1] = start_y_i;
    in_item_d.p3[0] = end_x_i;
    in_item_d.p3[1] = end_y_i;
    in_item_d.q1[0] = ctrl1_x_i;
    in_item_d.q1[1] = ctrl1_y_i;
    in_item_d.q2[0] = ctrl2_x_i;
    in_item_d.q2[1] = ctrl2_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_rdy) begin
      in_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && in_valid_i) in_item_q <= in_item_d;
  end

  // Quadratics get their two cubic controls here; lines route p3 into the
  // first control so the first interpolation lane yields the midpoint.
  bss_raise u_raise (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_v_q),
    .ready_o (raise_rdy),
    .item_i  (in_item_q),
    .valid_o (raise_v),
    .ready_i (l1_rdy),
    .item_o  (raise_item)
  );

  // First de Casteljau level: lanes 0 to 2 carry x, lanes 3 to 5 carry y.
  always_comb begin
    l1_a[0] = raise_item.p0[0];
    l1_b[0] = raise_item.q1[0];
    l1_a[1] = raise_item.q1[0];
    l1_b[1] = raise_item.q2[0];
    l1_a[2] = raise_item.q2[0];
    l1_b[2] = raise_item.p3[0];
    l1_a[3] = raise_item.p0[1];
    l1_b[3] = raise_item.q1[1];
    l1_a[4] = raise_item.q1[1];
    l1_b[4] = raise_item.q2[1];
    l1_a[5] = raise_item.q2[1];
    l1_b[5] = raise_item.p3[1];
  end

  bss_lerp u_lerp1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (raise_v),
    .ready_o (l1_rdy),
    .item_i  (raise_item),
    .a_i     (l1_a),
    .b_i     (l1_b),
    .valid_o (l1_v),
    .ready_i (l2_rdy),
    .item_o  (l1_side),
    .r_o     (l1_r)
  );

  always_comb begin
    l1_item        = l1_side;
    l1_item.a01[0] = l1_r[0];
    l1_item.a12[0] = l1_r[1];
    l1_item.a23[0] = l1_r[2];
    l1_item.a01[1] = l1_r[3];
    l1_item.a12[1] = l1_r[4];
    l1_item.a23[1] = l1_r[5];
  end

  // Second level: lanes 0 and 1 carry x, lanes 2 and 3 carry y, the rest idle.
  always_comb begin
    l2_a    = '0;
    l2_b    = '0;
    l2_a[0] = l1_item.a01[0];
    l2_b[0] = l1_item.a12[0];
    l2_a[1] = l1_item.a12[0];
    l2_b[1] = l1_item.a23[0];
    l2_a[2] = l1_item.a01[1];
    l2_b[2] = l1_item.a12[1];
    l2_a[3] = l1_item.a12[1];
    l2_b[3] = l1_item.a23[1];
  end

  bss_lerp u_lerp2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (l1_v),
    .ready_o (l2_rdy),
    .item_i  (l1_item),
    .a_i     (l2_a),
    .b_i     (l2_b),
    .valid_o (l2_v),
    .ready_i (l3_rdy),
    .item_o  (l2_side),
    .r_o     (l2_r)
  );

  always_comb begin
    l2_item         = l2_side;
    l2_item.b012[0] = l2_r[0];
    l2_item.b123[0] = l2_r[1];
    l2_item.b012[1] = l2_r[2];
    l2_item.b123[1] = l2_r[3];
  end

  // Third level: lane 0 carries x and lane 1 carries y.
  always_comb begin
    l3_a    = '0;
    l3_b    = '0;
    l3_a[0] = l2_item.b012[0];
    l3_b[0] = l2_item.b123[0];
    l3_a[1] = l2_item.b012[1];
    l3_b[1] = l2_item.b123[1];
  end

  bss_lerp u_lerp3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (l2_v),
    .ready_o (l3_rdy),
    .item_i  (l2_item),
    .a_i     (l3_a),
    .b_i     (l3_b),
    .valid_o (l3_v),
    .ready_i (out_rdy),
    .item_o  (l3_side),
    .r_o     (l3_r)
  );

  always_comb begin
    l3_item      = l3_side;
    l3_item.c[0] = l3_r[0];
    l3_item.c[1] = l3_r[1];
  end

  // The output register holds one finished segment and sends it as two halves.
  bss_out u_out (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (l3_v),
    .ready_o          (out_rdy),
    .item_i           (l3_item),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_kind_o       (out_kind_o),
    .is_second_half_o (is_second_half_o),
    .out_start_x_o    (out_start_x_o),
    .out_start_y_o    (out_start_y_o),
    .out_end_x_o      (out_end_x_o),
    .out_end_y_o      (out_end_y_o),
    .out_ctrl1_x_o    (out_ctrl1_x_o),
    .out_ctrl1_y_o    (out_ctrl1_y_o),
    .out_ctrl2_x_o    (out_ctrl2_x_o),
    .out_ctrl2_y_o    (out_ctrl2_y_o)
  );

  // A first half has just been transferred.
  assign first_xfer = out_valid_o && !out_stall_i && !is_second_half_o;

  // The second half is offered right after its first half goes out.
  `BSS_ASSERT_NXT(a_second_follows_first, first_xfer, out_valid_o && is_second_half_o, "second half did not follow its first half")

  // The two halves meet at the split point.
  `BSS_ASSERT_NXT(a_halves_join, first_xfer, out_start_x_o == $past(out_end_x_o) && out_start_y_o == $past(out_end_y_o), "second half does not start where the first half ended")

  // Line halves carry no control points.
  `BSS_ASSERT_IMP(a_line_ctrl_zero, out_valid_o && out_kind_o == bss_pkg::KIND_LINE, out_ctrl1_x_o == '0 && out_ctrl1_y_o == '0 && out_ctrl2_x_o == '0 && out_ctrl2_y_o == '0, "line half has nonzero control points")

endmodule
